/* hw/rtl/arc_path_point_sampler_unit_macros.svh */
`ifndef ARC_PATH_POINT_SAMPLER_UNIT_MACROS_SVH
`define ARC_PATH_POINT_SAMPLER_UNIT_MACROS_SVH

// same-cycle implication
`define APPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define APPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hw/rtl/apps_pkg.sv */
package apps_pkg;

    localparam int unsigned MAX_SAMPLES_DEF = 63;
    localparam int unsigned CORDIC_STEPS    = 20;
    localparam int unsigned STEP_W          = 5;
    localparam int unsigned NUM_W           = 40;
    localparam int unsigned QUOT_W          = 41;
    localparam int unsigned KMUL_STEPS      = 4;
    localparam logic signed [33:0] CORDIC_GAIN   = 34'sd652032874;
    localparam logic [57:0]        KANG          = 58'd183493156455125077;
    localparam logic [23:0]        SPACING_RESET = 24'd40960;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic [15:0]        start_heading;
        logic signed [31:0] curvature;
        logic [30:0]        arc_length;
    } t_in;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0]        heading;
        logic [47:0]        path_position;
        logic signed [31:0] sample_curvature;
        logic               last;
        logic               truncated;
    } t_out;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_SETUP,
        CMD_PLAN,
        CMD_EMIT_START,
        CMD_SMULX,
        CMD_SMULY,
        CMD_SFIN,
        CMD_MAG,
        CMD_ANGLE,
        CMD_NUMER,
        CMD_POSE,
        CMD_EMIT,
        CMD_FINISH
    } t_cmd;

    typedef struct packed {
        logic cordic_busy;
        logic kmul_busy;
        logic div_busy;
        logic out_free;
        logic first_item;
        logic none;
        logic curved;
        logic last;
    } t_status;

    function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
        logic signed [31:0] r;
        if (v > 42'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -42'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        logic signed [31:0] n;
        n = -v;
        return v[31] ? n : v;
    endfunction

endpackage

/* hw/rtl/apps_div.sv */
module apps_div
    import apps_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [NUM_W-1:0]  i_num,
    input  logic signed [31:0]       i_den,
    output logic                     o_busy,
    output logic signed [QUOT_W-1:0] o_quot
);

    localparam int unsigned CNT_W = $clog2(NUM_W);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [31:0]      r_rem;
    logic [NUM_W-1:0] r_dvd;
    logic [NUM_W-1:0] r_q;
    logic [31:0]      r_ud;
    logic             r_neg;

    logic [NUM_W-1:0] un;
    logic [31:0]      ud;
    logic [32:0]      trial;
    logic             qbit;
    logic [32:0]      diff;

    always_comb begin
        un    = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
        ud    = abs32(i_den);
        trial = {r_rem, r_dvd[NUM_W-1]};
        diff  = trial - {1'b0, r_ud};
        qbit  = (trial >= {1'b0, r_ud});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(NUM_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= un + NUM_W'(ud >> 1);
            r_q   <= '0;
            r_ud  <= ud;
            r_neg <= i_num[NUM_W-1] ^ i_den[31];
        end else if (r_busy) begin
            r_rem <= qbit ? diff[31:0] : trial[31:0];
            r_dvd <= {r_dvd[NUM_W-2:0], 1'b0};
            r_q   <= {r_q[NUM_W-2:0], qbit};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});

endmodule

/* hw/rtl/apps_ctrl.sv */
module apps_ctrl
    import apps_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_stall,
    output t_cmd    o_cmd
);

    typedef enum logic [16:0] {
        S_IDLE   = 17'h00001,
        S_SETUP  = 17'h00002,
        S_CORD0  = 17'h00004,
        S_PLAN   = 17'h00008,
        S_START  = 17'h00010,
        S_ST0    = 17'h00020,
        S_ST1    = 17'h00040,
        S_ST2    = 17'h00080,
        S_MAG    = 17'h00100,
        S_KMUL   = 17'h00200,
        S_ANGLE  = 17'h00400,
        S_CORD1  = 17'h00800,
        S_NUMER  = 17'h01000,
        S_DIV    = 17'h02000,
        S_POSE   = 17'h04000,
        S_EMIT   = 17'h08000,
        S_FINISH = 17'h10000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_state sample_entry;

    assign sample_entry = i_status.curved ? S_MAG : S_ST0;

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = CMD_LOAD;
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd   = CMD_SETUP;
                n_state = S_CORD0;
            end
            S_CORD0: begin
                if (!i_status.cordic_busy) begin
                    n_state = S_PLAN;
                end
            end
            S_PLAN: begin
                o_cmd   = CMD_PLAN;
                n_state = S_START;
            end
            S_START: begin
                if (!i_status.first_item || i_status.out_free) begin
                    if (i_status.first_item) begin
                        o_cmd = CMD_EMIT_START;
                    end
                    n_state = i_status.none ? S_FINISH : sample_entry;
                end
            end
            S_ST0: begin
                o_cmd   = CMD_SMULX;
                n_state = S_ST1;
            end
            S_ST1: begin
                o_cmd   = CMD_SMULY;
                n_state = S_ST2;
            end
            S_ST2: begin
                o_cmd   = CMD_SFIN;
                n_state = S_EMIT;
            end
            S_MAG: begin
                o_cmd   = CMD_MAG;
                n_state = S_KMUL;
            end
            S_KMUL: begin
                if (!i_status.kmul_busy) begin
                    n_state = S_ANGLE;
                end
            end
            S_ANGLE: begin
                o_cmd   = CMD_ANGLE;
                n_state = S_CORD1;
            end
            S_CORD1: begin
                if (!i_status.cordic_busy) begin
                    n_state = S_NUMER;
                end
            end
            S_NUMER: begin
                o_cmd   = CMD_NUMER;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (!i_status.div_busy) begin
                    n_state = S_POSE;
                end
            end
            S_POSE: begin
                o_cmd   = CMD_POSE;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd   = CMD_EMIT;
                    n_state = i_status.last ? S_FINISH : sample_entry;
                end
            end
            S_FINISH: begin
                o_cmd   = CMD_FINISH;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

/* hw/rtl/apps_dp.sv */
module apps_dp
    import apps_pkg::*;
#(
    parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  t_in         i_in_data,
    input  logic        i_cfg_valid,
    input  logic [23:0] i_cfg_data,
    input  logic        i_out_stall,
    output t_status     o_status,
    output logic        o_out_valid,
    output t_out        o_out_data
);

    localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int unsigned KS_W  = $clog2(KMUL_STEPS + 1);

    logic [23:0] r_spacing;
    logic        r_started;
    logic [47:0] r_lastpos;
    logic [31:0] r_leftover;

    t_in              r_item;
    logic             r_first_item;
    logic [31:0]      r_prev_left;
    logic [31:0]      r_first;
    logic [47:0]      r_s0;
    logic             r_none;
    logic             r_trunc;
    logic [31:0]      r_off;
    logic [31:0]      r_lastoff;
    logic [CNT_W-1:0] r_cnt;

    logic                    r_crun;
    logic [STEP_W-1:0]       r_ci;
    logic signed [33:0]      r_cx;
    logic signed [33:0]      r_cy;
    logic signed [33:0]      r_cz;
    logic [1:0]              r_cq;
    logic signed [31:0]      r_cos0;
    logic signed [31:0]      r_sin0;

    logic [63:0]     r_prod;
    logic [62:0]     r_mag;
    logic [95:0]     r_acc;
    logic            r_krun;
    logic [KS_W-1:0] r_kstep;

    logic [15:0]        r_hd;
    logic signed [31:0] r_px;
    logic signed [31:0] r_py;

    logic r_out_valid;
    t_out r_out;

    logic                    out_free;
    logic                    is_last;
    logic [31:0]             first_c;
    logic [32:0]             span_c;
    logic [32:0]             off_next;
    logic                    cor_start;
    logic [31:0]             cor_ang;
    logic [31:0]             qsum;
    logic [31:0]             cor_r;
    logic signed [33:0]      c_dx;
    logic signed [33:0]      c_dy;
    logic signed [33:0]      c_at;
    logic signed [33:0]      nx;
    logic signed [33:0]      ny;
    logic signed [31:0]      cor_c;
    logic signed [31:0]      cor_s;
    logic [31:0]             mul_a;
    logic [31:0]             mul_b;
    logic [63:0]             mul_p;
    logic [95:0]             kadd;
    logic [31:0]             dang;
    logic [31:0]             ang_c;
    logic [31:0]             hd_c;
    logic signed [NUM_W-1:0] numx;
    logic signed [NUM_W-1:0] numy;
    logic signed [QUOT_W-1:0] qx;
    logic signed [QUOT_W-1:0] qy;
    logic                    busy_x;
    logic                    busy_y;

    function automatic logic signed [31:0] round30(input logic [63:0] p, input logic neg,
                                                   input logic signed [31:0] base);
        logic [63:0]        s;
        logic signed [34:0] q;
        s = p + 64'h2000_0000;
        q = neg ? -$signed({1'b0, s[63:30]}) : $signed({1'b0, s[63:30]});
        return sat32({{10{base[31]}}, base} + {{7{q[34]}}, q});
    endfunction

    assign out_free = !r_out_valid || !i_out_stall;
    assign off_next = {1'b0, r_off} + {9'b0, r_spacing};
    assign is_last  = (off_next > {2'b0, r_item.arc_length})
                   || (r_cnt == CNT_W'(MAX_SAMPLES - 1));

    always_comb begin
        if (!r_started) begin
            first_c = {8'b0, r_spacing};
        end else if (r_leftover >= {8'b0, r_spacing}) begin
            first_c = '0;
        end else begin
            first_c = {8'b0, r_spacing} - r_leftover;
        end
        span_c = {1'b0, r_first}
               + ({9'b0, r_spacing} * {{(33 - CNT_W){1'b0}}, CNT_W'(MAX_SAMPLES)});
    end

    always_comb begin
        dang  = r_acc[95:64];
        ang_c = {r_item.start_heading, 16'b0} + (r_item.curvature[31] ? (32'd0 - dang) : dang);
        hd_c  = ang_c + 32'h0000_8000;
        cor_start = (i_cmd == CMD_SETUP) || (i_cmd == CMD_ANGLE);
        cor_ang   = (i_cmd == CMD_ANGLE) ? ang_c : {r_item.start_heading, 16'b0};
        qsum  = cor_ang + 32'h2000_0000;
        cor_r = cor_ang - {qsum[31:30], 30'b0};
        c_dx  = r_cy >>> r_ci;
        c_dy  = r_cx >>> r_ci;
        c_at  = $signed({2'b0, atan_turn(r_ci)});
        nx    = -r_cx;
        ny    = -r_cy;
        case (r_cq)
            2'd0: begin
                cor_c = r_cx[31:0];
                cor_s = r_cy[31:0];
            end
            2'd1: begin
                cor_c = ny[31:0];
                cor_s = r_cx[31:0];
            end
            2'd2: begin
                cor_c = nx[31:0];
                cor_s = ny[31:0];
            end
            default: begin
                cor_c = r_cy[31:0];
                cor_s = nx[31:0];
            end
        endcase
    end

    always_comb begin
        case (i_cmd)
            CMD_SMULX: begin
                mul_a = abs32(r_cos0);
                mul_b = r_off;
            end
            CMD_SMULY: begin
                mul_a = abs32(r_sin0);
                mul_b = r_off;
            end
            CMD_MAG: begin
                mul_a = abs32(r_item.curvature);
                mul_b = r_off;
            end
            default: begin
                case (r_kstep)
                    KS_W'(0): begin
                        mul_a = r_mag[31:0];
                        mul_b = KANG[31:0];
                    end
                    KS_W'(1): begin
                        mul_a = r_mag[31:0];
                        mul_b = {6'b0, KANG[57:32]};
                    end
                    KS_W'(2): begin
                        mul_a = {1'b0, r_mag[62:32]};
                        mul_b = KANG[31:0];
                    end
                    default: begin
                        mul_a = {1'b0, r_mag[62:32]};
                        mul_b = {6'b0, KANG[57:32]};
                    end
                endcase
            end
        endcase
        mul_p = {32'b0, mul_a} * {32'b0, mul_b};
        case (r_kstep)
            KS_W'(1): kadd = {32'b0, r_prod};
            KS_W'(2), KS_W'(3): kadd = {r_prod, 32'b0};
            default: kadd = {r_prod[31:0], 64'b0};
        endcase
        numx = ({{8{cor_s[31]}}, cor_s} - {{8{r_sin0[31]}}, r_sin0}) <<< 6;
        numy = ({{8{r_cos0[31]}}, r_cos0} - {{8{cor_c[31]}}, cor_c}) <<< 6;
    end

    apps_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd == CMD_NUMER),
        .i_num   (numx),
        .i_den   (r_item.curvature),
        .o_busy  (busy_x),
        .o_quot  (qx)
    );

    apps_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd == CMD_NUMER),
        .i_num   (numy),
        .i_den   (r_item.curvature),
        .o_busy  (busy_y),
        .o_quot  (qy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spacing   <= SPACING_RESET;
            r_started   <= 1'b0;
            r_lastpos   <= '0;
            r_leftover  <= '0;
            r_crun      <= 1'b0;
            r_krun      <= 1'b0;
            r_kstep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_spacing <= i_cfg_data;
            end
            if (i_cmd == CMD_SETUP) begin
                r_started <= 1'b1;
            end
            if (i_cmd == CMD_FINISH) begin
                if (r_cnt != '0) begin
                    r_lastpos  <= r_s0 + {16'b0, r_lastoff};
                    r_leftover <= {1'b0, r_item.arc_length} - r_lastoff;
                end else begin
                    r_leftover <= {1'b0, r_item.arc_length} + r_prev_left;
                end
            end
            if (cor_start) begin
                r_crun <= 1'b1;
            end else if (r_crun && (r_ci == STEP_W'(CORDIC_STEPS - 1))) begin
                r_crun <= 1'b0;
            end
            if (i_cmd == CMD_MAG) begin
                r_krun  <= 1'b1;
                r_kstep <= '0;
            end else if (r_krun) begin
                r_kstep <= r_kstep + 1'b1;
                if (r_kstep == KS_W'(KMUL_STEPS)) begin
                    r_krun <= 1'b0;
                end
            end
            if ((i_cmd == CMD_EMIT) || (i_cmd == CMD_EMIT_START)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_LOAD) begin
            r_item <= i_in_data;
        end
        if (i_cmd == CMD_SETUP) begin
            r_first_item <= !r_started;
            r_prev_left  <= r_started ? r_leftover : '0;
            r_first      <= first_c;
            r_s0         <= r_started ? (r_lastpos + {16'b0, r_leftover}) : '0;
        end
        if (i_cmd == CMD_PLAN) begin
            r_cos0  <= cor_c;
            r_sin0  <= cor_s;
            r_trunc <= (span_c <= {2'b0, r_item.arc_length});
            r_none  <= (r_first > {1'b0, r_item.arc_length});
            r_off   <= r_first;
            r_cnt   <= '0;
        end
        if (cor_start) begin
            r_ci <= '0;
            r_cq <= qsum[31:30];
            r_cx <= CORDIC_GAIN;
            r_cy <= '0;
            r_cz <= {{2{cor_r[31]}}, cor_r};
        end else if (r_crun) begin
            r_ci <= r_ci + 1'b1;
            if (!r_cz[33]) begin
                r_cx <= r_cx - c_dx;
                r_cy <= r_cy + c_dy;
                r_cz <= r_cz - c_at;
            end else begin
                r_cx <= r_cx + c_dx;
                r_cy <= r_cy - c_dy;
                r_cz <= r_cz + c_at;
            end
        end
        if ((i_cmd == CMD_SMULX) || (i_cmd == CMD_SMULY)
            || (r_krun && (r_kstep != KS_W'(KMUL_STEPS)))) begin
            r_prod <= mul_p;
        end
        if (i_cmd == CMD_MAG) begin
            r_mag <= mul_p[62:0];
            r_acc <= '0;
        end else if (r_krun && (r_kstep != '0)) begin
            r_acc <= r_acc + kadd;
        end
        if (i_cmd == CMD_SMULY) begin
            r_px <= round30(r_prod, r_cos0[31], r_item.start_x);
        end
        if (i_cmd == CMD_SFIN) begin
            r_py <= round30(r_prod, r_sin0[31], r_item.start_y);
            r_hd <= r_item.start_heading;
        end
        if (i_cmd == CMD_ANGLE) begin
            r_hd <= hd_c[31:16];
        end
        if (i_cmd == CMD_POSE) begin
            r_px <= sat32({{10{r_item.start_x[31]}}, r_item.start_x} + {qx[QUOT_W-1], qx});
            r_py <= sat32({{10{r_item.start_y[31]}}, r_item.start_y} + {qy[QUOT_W-1], qy});
        end
        if (i_cmd == CMD_EMIT_START) begin
            r_out.pos_x            <= r_item.start_x;
            r_out.pos_y            <= r_item.start_y;
            r_out.heading          <= r_item.start_heading;
            r_out.path_position    <= '0;
            r_out.sample_curvature <= r_item.curvature;
            r_out.last             <= r_none;
            r_out.truncated        <= r_trunc;
        end
        if (i_cmd == CMD_EMIT) begin
            r_out.pos_x            <= r_px;
            r_out.pos_y            <= r_py;
            r_out.heading          <= r_hd;
            r_out.path_position    <= r_s0 + {16'b0, r_off};
            r_out.sample_curvature <= r_item.curvature;
            r_out.last             <= is_last;
            r_out.truncated        <= r_trunc;
            r_lastoff              <= r_off;
            r_off                  <= off_next[31:0];
            r_cnt                  <= r_cnt + 1'b1;
        end
    end

    always_comb begin
        o_status.cordic_busy = r_crun;
        o_status.kmul_busy   = r_krun;
        o_status.div_busy    = busy_x || busy_y;
        o_status.out_free    = out_free;
        o_status.first_item  = r_first_item;
        o_status.none        = r_none;
        o_status.curved      = (r_item.curvature != '0);
        o_status.last        = is_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* hw/rtl/arc_path_point_sampler_unit.sv */
// The first item after reset also emits its start pose before its samples.
// Straight arc: each sample passes S_ST0, S_ST1, S_ST2 and S_EMIT; a curved-arc sample waits on
// the 20-step CORDIC and the bit-serial dividers for x and y.
// One request at a time: a new request is taken only after the previous arc has emitted its
// n samples, n up to MAX_SAMPLES; a stalled output holds the arc longer.
// Reset: synchronous, active low; clears the controller, path state and spacing (10.0).
module arc_path_point_sampler_unit
    import apps_pkg::*;
#(
    parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [23:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    apps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    apps_dp #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    assign o_cfg_ready = 1'b1;

endmodule

/* hw/rtl/apps_chk.sv */
`include "arc_path_point_sampler_unit_macros.svh"

module apps_chk
    import apps_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input t_in         i_in_data,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input t_out        o_out_data,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [23:0] i_cfg_data
);

    `APPS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `APPS_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_data))
    `APPS_ASSERT_NOW(a_busy_mid_arc, i_clk, i_rst_n, o_out_valid && !o_out_data.last, o_in_stall)
    `APPS_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

endmodule

bind arc_path_point_sampler_unit apps_chk u_apps_chk (.*);
